### sv/md5sh_pkg.sv
// Package for the MD5 stream hasher: commands, initial chaining words,
// round constants, rotate amounts and the message word schedule.
// No dependencies.
package md5sh_pkg;

   localparam logic [1:0] CMD_DATA        = 2'd0;
   localparam logic [1:0] CMD_DATA_FINISH = 2'd1;
   localparam logic [1:0] CMD_FINISH      = 2'd2;

   localparam logic [31:0] INIT_A = 32'h67452301;
   localparam logic [31:0] INIT_B = 32'hefcdab89;
   localparam logic [31:0] INIT_C = 32'h98badcfe;
   localparam logic [31:0] INIT_D = 32'h10325476;

   localparam logic [7:0] PAD_BYTE = 8'h80;
   localparam logic [5:0] LEN_POS  = 6'd56;

   typedef struct packed {
      logic       start;   // compress the block just filled
      logic       busy;    // tied low by the top level; the core does not read it
   } comp_ctl_type;

   function automatic logic [31:0] round_const(input logic [5:0] i);
      logic [31:0] k;
      case (i)
         6'd0: k = 32'hd76aa478;  6'd1: k = 32'he8c7b756;
         6'd2: k = 32'h242070db;  6'd3: k = 32'hc1bdceee;
         6'd4: k = 32'hf57c0faf;  6'd5: k = 32'h4787c62a;
         6'd6: k = 32'ha8304613;  6'd7: k = 32'hfd469501;
         6'd8: k = 32'h698098d8;  6'd9: k = 32'h8b44f7af;
         6'd10: k = 32'hffff5bb1; 6'd11: k = 32'h895cd7be;
         6'd12: k = 32'h6b901122; 6'd13: k = 32'hfd987193;
         6'd14: k = 32'ha679438e; 6'd15: k = 32'h49b40821;
         6'd16: k = 32'hf61e2562; 6'd17: k = 32'hc040b340;
         6'd18: k = 32'h265e5a51; 6'd19: k = 32'he9b6c7aa;
         6'd20: k = 32'hd62f105d; 6'd21: k = 32'h02441453;
         6'd22: k = 32'hd8a1e681; 6'd23: k = 32'he7d3fbc8;
         6'd24: k = 32'h21e1cde6; 6'd25: k = 32'hc33707d6;
         6'd26: k = 32'hf4d50d87; 6'd27: k = 32'h455a14ed;
         6'd28: k = 32'ha9e3e905; 6'd29: k = 32'hfcefa3f8;
         6'd30: k = 32'h676f02d9; 6'd31: k = 32'h8d2a4c8a;
         6'd32: k = 32'hfffa3942; 6'd33: k = 32'h8771f681;
         6'd34: k = 32'h6d9d6122; 6'd35: k = 32'hfde5380c;
         6'd36: k = 32'ha4beea44; 6'd37: k = 32'h4bdecfa9;
         6'd38: k = 32'hf6bb4b60; 6'd39: k = 32'hbebfbc70;
         6'd40: k = 32'h289b7ec6; 6'd41: k = 32'heaa127fa;
         6'd42: k = 32'hd4ef3085; 6'd43: k = 32'h04881d05;
         6'd44: k = 32'hd9d4d039; 6'd45: k = 32'he6db99e5;
         6'd46: k = 32'h1fa27cf8; 6'd47: k = 32'hc4ac5665;
         6'd48: k = 32'hf4292244; 6'd49: k = 32'h432aff97;
         6'd50: k = 32'hab9423a7; 6'd51: k = 32'hfc93a039;
         6'd52: k = 32'h655b59c3; 6'd53: k = 32'h8f0ccc92;
         6'd54: k = 32'hffeff47d; 6'd55: k = 32'h85845dd1;
         6'd56: k = 32'h6fa87e4f; 6'd57: k = 32'hfe2ce6e0;
         6'd58: k = 32'ha3014314; 6'd59: k = 32'h4e0811a1;
         6'd60: k = 32'hf7537e82; 6'd61: k = 32'hbd3af235;
         6'd62: k = 32'h2ad7d2bb; 6'd63: k = 32'heb86d391;
         default: k = 32'h0;
      endcase
      return k;
   endfunction

   function automatic logic [4:0] rot_amount(input logic [5:0] i);
      logic [4:0] s;
      case ({i[5:4], i[1:0]})
         4'h0: s = 5'd7;  4'h1: s = 5'd12; 4'h2: s = 5'd17; 4'h3: s = 5'd22;
         4'h4: s = 5'd5;  4'h5: s = 5'd9;  4'h6: s = 5'd14; 4'h7: s = 5'd20;
         4'h8: s = 5'd4;  4'h9: s = 5'd11; 4'ha: s = 5'd16; 4'hb: s = 5'd23;
         4'hc: s = 5'd6;  4'hd: s = 5'd10; 4'he: s = 5'd15; 4'hf: s = 5'd21;
         default: s = 5'd0;
      endcase
      return s;
   endfunction

   // Message word index used by round i.
   function automatic logic [3:0] word_sel(input logic [5:0] i);
      logic [3:0] g;
      logic [3:0] r;
      r = i[3:0];
      case (i[5:4])
         2'd0: g = r;
         2'd1: g = 4'(5 * r + 1);
         2'd2: g = 4'(3 * r + 5);
         2'd3: g = 4'(7 * r);
         default: g = r;
      endcase
      return g;
   endfunction

endpackage

### sv/md5sh_core.sv
// MD5 compression engine: one round per cycle over a 16-word block read
// from the block word memory of the top level. Depends on md5sh_pkg.
module md5sh_core (
   input  logic                     clock,
   input  logic                     reset,
   input  md5sh_pkg::comp_ctl_type  ctl_in,
   input  logic                     reinit,
   output logic [3:0]               rd_word,
   output logic                     rd_en,
   input  logic [31:0]              rd_data,
   output logic                     busy,
   output logic [31:0]              chain_a,
   output logic [31:0]              chain_b,
   output logic [31:0]              chain_c,
   output logic [31:0]              chain_d
);

   typedef enum logic [1:0] {S_IDLE, S_ROUND, S_FOLD} state_type;

   state_type   state_ff;
   logic [6:0]  rnd_ff;     // round whose word is being fetched, 64 = done fetching
   logic [5:0]  exec_ff;    // round executing this cycle
   logic        exec_v_ff;
   logic [31:0] a_ff, b_ff, c_ff, d_ff;
   logic [31:0] h0_ff, h1_ff, h2_ff, h3_ff;
   logic [31:0] f, sum, rot;
   logic [4:0]  sh;

   assign rd_en   = (state_ff == S_ROUND) && !rnd_ff[6];
   assign rd_word = md5sh_pkg::word_sel(rnd_ff[5:0]);
   assign busy    = (state_ff != S_IDLE);
   assign chain_a = h0_ff;
   assign chain_b = h1_ff;
   assign chain_c = h2_ff;
   assign chain_d = h3_ff;

   always_comb begin
      case (exec_ff[5:4])
         2'd0: f = (b_ff & c_ff) | (~b_ff & d_ff);
         2'd1: f = (b_ff & d_ff) | (c_ff & ~d_ff);
         2'd2: f = b_ff ^ c_ff ^ d_ff;
         default: f = c_ff ^ (b_ff | ~d_ff);
      endcase
      sum = a_ff + f + md5sh_pkg::round_const(exec_ff) + rd_data;
      sh  = md5sh_pkg::rot_amount(exec_ff);
      rot = (sum << sh) | (sum >> (6'd32 - {1'b0, sh}));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         exec_v_ff <= 1'b0;
         rnd_ff    <= '0;
         exec_ff   <= '0;
         h0_ff <= md5sh_pkg::INIT_A; h1_ff <= md5sh_pkg::INIT_B;
         h2_ff <= md5sh_pkg::INIT_C; h3_ff <= md5sh_pkg::INIT_D;
      end else begin
         case (state_ff)
            S_IDLE: begin
               if (reinit) begin
                  h0_ff <= md5sh_pkg::INIT_A; h1_ff <= md5sh_pkg::INIT_B;
                  h2_ff <= md5sh_pkg::INIT_C; h3_ff <= md5sh_pkg::INIT_D;
               end
               if (ctl_in.start) begin
                  state_ff  <= S_ROUND;
                  rnd_ff    <= '0;
                  exec_v_ff <= 1'b0;
                  a_ff <= h0_ff; b_ff <= h1_ff; c_ff <= h2_ff; d_ff <= h3_ff;
               end
            end
            S_ROUND: begin
               exec_v_ff <= !rnd_ff[6];
               exec_ff   <= rnd_ff[5:0];
               if (!rnd_ff[6]) rnd_ff <= rnd_ff + 7'd1;
               if (exec_v_ff) begin
                  a_ff <= d_ff;
                  d_ff <= c_ff;
                  c_ff <= b_ff;
                  b_ff <= b_ff + rot;
                  if (exec_ff == 6'd63) state_ff <= S_FOLD;
               end
            end
            S_FOLD: begin
               h0_ff <= h0_ff + a_ff; h1_ff <= h1_ff + b_ff;
               h2_ff <= h2_ff + c_ff; h3_ff <= h3_ff + d_ff;
               exec_v_ff <= 1'b0;
               state_ff  <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

endmodule

### sv/md5_stream_hasher.sv
// Top level of the MD5 stream hasher: byte gathering, padding sequencer,
// block word memory and digest output. Depends on md5sh_pkg, md5sh_core.
//
//  channel | direction | ports
//  req     | in        | req_valid req_ready req_cmd req_data_byte
//  rsp     | out       | rsp_valid rsp_ready rsp_digest_word rsp_word_index rsp_last_word
//
// A data byte transaction that completes a block drops req_ready while the
// block is compressed (one MD5 round per cycle, set by the single read port
// of the block word memory). A finish adds the padding bytes one per cycle
// while no compression runs, plus one or two compressions, and then four
// response transactions, one per cycle while rsp_ready is high.
// Reset is synchronous and active high; the block memory needs no clearing.
// A stalled response holds its word; no request is taken until all four leave.
module md5_stream_hasher (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_cmd,
   input  logic [7:0]  req_data_byte,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [31:0] rsp_digest_word,
   output logic [1:0]  rsp_word_index,
   output logic        rsp_last_word
);

   typedef enum logic [1:0] {S_ACCEPT, S_PAD, S_WAIT, S_OUT} state_type;

   state_type    state_ff;
   logic [60:0]  count_ff;        // bytes absorbed, padding included
   logic [63:0]  bits_ff;         // bit length latched at finish
   logic         len_phase_ff;    // padding has reached the length field
   logic         pad_first_ff;    // next padding byte is the 0x80 marker
   logic [23:0]  part_ff;         // low bytes of the word being gathered
   logic [1:0]   idx_ff;
   logic         reinit_ff;
   logic [31:0]  wmem [16];       // block held as little-endian words
   logic [31:0]  rd_data_ff;

   logic         absorb;
   logic [7:0]   abs_byte;
   logic [60:0]  count_next;
   logic         blk_full;
   logic         req_fire;
   logic         rd_en;
   logic [3:0]   rd_word;
   logic         core_busy;
   logic [31:0]  ha, hb, hc, hd;
   md5sh_pkg::comp_ctl_type ctl;

   assign req_fire   = req_valid && req_ready;
   assign req_ready  = (state_ff == S_ACCEPT) && !core_busy;
   assign count_next = count_ff + 61'd1;
   assign blk_full   = absorb && (count_ff[5:0] == 6'd63);
   assign ctl.start  = blk_full;
   assign ctl.busy   = 1'b0;

   // Byte source: request data in the accept state, padding bytes in the pad state.
   // The first padding byte is 0x80; the rest up to the length field are zero.
   always_comb begin
      absorb   = 1'b0;
      abs_byte = req_data_byte;
      if (state_ff == S_ACCEPT) begin
         absorb = req_fire && (req_cmd == md5sh_pkg::CMD_DATA
                               || req_cmd == md5sh_pkg::CMD_DATA_FINISH);
      end else if (state_ff == S_PAD && !core_busy) begin
         absorb = 1'b1;
         if (!len_phase_ff) begin
            abs_byte = pad_first_ff ? md5sh_pkg::PAD_BYTE : 8'h00;
         end else begin
            abs_byte = bits_ff[{count_ff[2:0], 3'b000} +: 8];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (absorb && count_ff[1:0] == 2'd3)
         wmem[count_ff[5:2]] <= {abs_byte, part_ff};
      if (rd_en)
         rd_data_ff <= wmem[rd_word];
      if (absorb) begin
         case (count_ff[1:0])
            2'd0: part_ff[7:0]   <= abs_byte;
            2'd1: part_ff[15:8]  <= abs_byte;
            2'd2: part_ff[23:16] <= abs_byte;
            default: part_ff <= part_ff;
         endcase
      end
   end

   md5sh_core u_core (
      .clock(clock), .reset(reset), .ctl_in(ctl), .reinit(reinit_ff),
      .rd_word(rd_word), .rd_en(rd_en), .rd_data(rd_data_ff), .busy(core_busy),
      .chain_a(ha), .chain_b(hb), .chain_c(hc), .chain_d(hd)
   );

   always_comb begin
      case (idx_ff)
         2'd0: rsp_digest_word = ha;
         2'd1: rsp_digest_word = hb;
         2'd2: rsp_digest_word = hc;
         default: rsp_digest_word = hd;
      endcase
   end
   assign rsp_valid      = (state_ff == S_OUT) && !core_busy;
   assign rsp_word_index = idx_ff;
   assign rsp_last_word  = (idx_ff == 2'd3);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_ACCEPT;
         count_ff     <= '0;
         len_phase_ff <= 1'b0;
         idx_ff       <= '0;
         reinit_ff    <= 1'b0;
         pad_first_ff <= 1'b0;
      end else begin
         reinit_ff <= 1'b0;
         if (absorb) count_ff <= count_next;
         case (state_ff)
            S_ACCEPT: begin
               if (req_fire && (req_cmd == md5sh_pkg::CMD_DATA_FINISH
                                || req_cmd == md5sh_pkg::CMD_FINISH)) begin
                  state_ff     <= S_PAD;
                  len_phase_ff <= 1'b0;
                  pad_first_ff <= 1'b1;
                  if (req_cmd == md5sh_pkg::CMD_DATA_FINISH)
                     bits_ff <= {count_next, 3'b000};
                  else
                     bits_ff <= {count_ff, 3'b000};
               end
            end
            S_PAD: begin
               if (absorb) begin
                  pad_first_ff <= 1'b0;
                  if (!len_phase_ff && count_next[5:0] == md5sh_pkg::LEN_POS)
                     len_phase_ff <= 1'b1;
                  if (len_phase_ff && count_ff[5:0] == 6'd63)
                     state_ff <= S_WAIT;
               end
            end
            S_WAIT: begin
               if (!core_busy) begin
                  state_ff <= S_OUT;
                  idx_ff   <= '0;
               end
            end
            S_OUT: begin
               if (rsp_valid && rsp_ready) begin
                  idx_ff <= idx_ff + 2'd1;
                  if (idx_ff == 2'd3) begin
                     state_ff  <= S_ACCEPT;
                     count_ff  <= '0;
                     reinit_ff <= 1'b1;
                  end
               end
            end
            default: state_ff <= S_ACCEPT;
         endcase
      end
   end

endmodule

### sv/md5sh_checker.sv
// Port checker for the MD5 stream hasher, bound to the top level.
// Depends only on the top level's ports.
module md5sh_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [1:0]  rsp_word_index,
   input logic        rsp_last_word,
   input logic [31:0] rsp_digest_word
);

   a_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_last_word == (rsp_word_index == 2'd3)))
      else $error("last_word disagrees with word_index");

   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready)
      else $error("request taken while digest pending");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_digest_word))
      else $error("stalled digest word changed");

   a_order: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_last_word |=>
         rsp_word_index == $past(rsp_word_index) + 2'd1)
      else $error("digest words out of order");

endmodule

bind md5_stream_hasher md5sh_checker u_md5sh_checker (
   .clock(clock), .reset(reset), .req_valid(req_valid), .req_ready(req_ready),
   .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_word_index(rsp_word_index),
   .rsp_last_word(rsp_last_word), .rsp_digest_word(rsp_digest_word)
);

### verif/md5_stream_hasher_checker.sv
// Checker for the MD5 stream hasher: watches both channels, predicts each
// digest word with its own MD5 model and compares. Depends on md5sh_pkg.
module md5_stream_hasher_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  logic [1:0]  req_cmd,
   input  logic [7:0]  req_data_byte,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  logic [31:0] rsp_digest_word,
   input  logic [1:0]  rsp_word_index,
   input  logic        rsp_last_word,
   output int          fail_count,
   output int          words_pending
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [31:0] word;
      logic [1:0]  index;
      logic        last;
   } digest_word_type;

   logic [31:0]     chain [4];
   logic [7:0]      msg_block [64];
   logic [60:0]     msg_bytes;
   digest_word_type digest_queue [$];

   function automatic logic [31:0] sine_const(int i);
      logic [31:0] k [64] = '{
         32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee, 32'hf57c0faf,
         32'h4787c62a, 32'ha8304613, 32'hfd469501, 32'h698098d8, 32'h8b44f7af,
         32'hffff5bb1, 32'h895cd7be, 32'h6b901122, 32'hfd987193, 32'ha679438e,
         32'h49b40821, 32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
         32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8, 32'h21e1cde6,
         32'hc33707d6, 32'hf4d50d87, 32'h455a14ed, 32'ha9e3e905, 32'hfcefa3f8,
         32'h676f02d9, 32'h8d2a4c8a, 32'hfffa3942, 32'h8771f681, 32'h6d9d6122,
         32'hfde5380c, 32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
         32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05, 32'hd9d4d039,
         32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665, 32'hf4292244, 32'h432aff97,
         32'hab9423a7, 32'hfc93a039, 32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d,
         32'h85845dd1, 32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
         32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391};
      return k[i];
   endfunction

   task automatic compress_block();
      int shifts [16] = '{7, 12, 17, 22, 5, 9, 14, 20, 4, 11, 16, 23, 6, 10, 15, 21};
      logic [31:0] w [16];
      logic [31:0] a, b, c, d, f, sum, tmp;
      int g, grp;
      a = chain[0]; b = chain[1]; c = chain[2]; d = chain[3];
      for (int i = 0; i < 16; i++)
         w[i] = {msg_block[4*i+3], msg_block[4*i+2], msg_block[4*i+1], msg_block[4*i]};
      for (int i = 0; i < 64; i++) begin
         grp = i / 16;
         case (grp)
            0: begin f = (b & c) | (~b & d); g = i; end
            1: begin f = (b & d) | (c & ~d); g = (5*i + 1) % 16; end
            2: begin f = b ^ c ^ d;          g = (3*i + 5) % 16; end
            default: begin f = c ^ (b | ~d); g = (7*i) % 16; end
         endcase
         sum = a + f + sine_const(i) + w[g];
         tmp = d; d = c; c = b;
         b = b + ((sum << shifts[grp*4 + i%4]) | (sum >> (32 - shifts[grp*4 + i%4])));
         a = tmp;
      end
      chain[0] += a; chain[1] += b; chain[2] += c; chain[3] += d;
   endtask

   task automatic absorb_byte(logic [7:0] v);
      msg_block[msg_bytes[5:0]] = v;
      msg_bytes = msg_bytes + 61'd1;
      if (msg_bytes[5:0] == 6'd0) compress_block();
   endtask

   task automatic start_message();
      chain = '{md5sh_pkg::INIT_A, md5sh_pkg::INIT_B, md5sh_pkg::INIT_C, md5sh_pkg::INIT_D};
      msg_bytes = '0;
   endtask

   task automatic finish_message();
      logic [63:0] bit_len;
      digest_word_type dw;
      bit_len = {msg_bytes, 3'b000};
      absorb_byte(md5sh_pkg::PAD_BYTE);
      while (msg_bytes[5:0] != md5sh_pkg::LEN_POS) absorb_byte(8'h00);
      for (int k = 0; k < 8; k++) absorb_byte(bit_len[8*k +: 8]);
      for (int k = 0; k < 4; k++) begin
         dw.word = chain[k];
         dw.index = 2'(k);
         dw.last = (k == 3);
         digest_queue.push_back(dw);
      end
      start_message();
   endtask

   task automatic report_mismatch(string what);
      $display("%0t ns: mismatch: %s", $time, what);
      fail_count++;
   endtask

   initial begin
      fail_count = 0;
      words_pending = 0;
      start_message();
   end

   always @(posedge clock) begin
      digest_word_type exp_w;
      if (reset) begin
         start_message();
      end else begin
         if (req_valid && req_ready) begin
            if (req_cmd == md5sh_pkg::CMD_DATA || req_cmd == md5sh_pkg::CMD_DATA_FINISH)
               absorb_byte(req_data_byte);
            if (req_cmd == md5sh_pkg::CMD_DATA_FINISH || req_cmd == md5sh_pkg::CMD_FINISH)
               finish_message();
         end
         if (rsp_valid && rsp_ready) begin
            if (digest_queue.size() == 0) begin
               report_mismatch($sformatf("unexpected digest word %h", rsp_digest_word));
            end else begin
               exp_w = digest_queue.pop_front();
               if (rsp_digest_word != exp_w.word)
                  report_mismatch($sformatf("digest_word %h, want %h",
                                            rsp_digest_word, exp_w.word));
               if (rsp_word_index != exp_w.index)
                  report_mismatch($sformatf("word_index %0d, want %0d",
                                            rsp_word_index, exp_w.index));
               if (rsp_last_word != exp_w.last)
                  report_mismatch($sformatf("last_word %0d, want %0d",
                                            rsp_last_word, exp_w.last));
            end
         end
      end
      words_pending = digest_queue.size();
   end
endmodule

### verif/md5_stream_hasher_tb.sv
// Top of the MD5 stream hasher testbench: clock, reset, message stimulus
// and verdict. Depends on md5sh_pkg, md5_stream_hasher and its checker.
module md5_stream_hasher_tb;
   timeunit 1ns;
   timeprecision 1ps;

   // The unused command code; the block must ignore it entirely.
   localparam logic [1:0] CMD_IGNORED = 2'd3;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [1:0]  req_cmd = md5sh_pkg::CMD_DATA;
   logic [7:0]  req_data_byte = 8'h00;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [31:0] rsp_digest_word;
   logic [1:0]  rsp_word_index;
   logic        rsp_last_word;
   int          fail_count;
   int          words_pending;
   int          burst_left = 0;

   md5_stream_hasher uut (.*);

   md5_stream_hasher_checker checker_i (.*);

   initial begin
      forever #6 clock = ~clock;
   end

   // Sends one request transaction. The sender runs in bursts; when a burst
   // is used up it drops valid for a random gap before the next one starts.
   task automatic send_request(logic [1:0] cmd, logic [7:0] data);
      if (burst_left == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(0, 6)) @(negedge clock);
         burst_left = $urandom_range(1, 20);
      end
      req_valid <= 1'b1;
      req_cmd <= cmd;
      req_data_byte <= data;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
      burst_left--;
   endtask

   // A message of random bytes, closed by a finish with or without a byte.
   task automatic send_message(int len, bit with_byte);
      for (int i = 0; i < len; i++) send_request(md5sh_pkg::CMD_DATA, 8'($urandom));
      if (with_byte) send_request(md5sh_pkg::CMD_DATA_FINISH, 8'($urandom));
      else send_request(md5sh_pkg::CMD_FINISH, 8'($urandom));
   endtask

   // The receiver stalls in a pattern of its own: sometimes ready stays high
   // for long stretches, sometimes it toggles randomly.
   initial begin
      int mode;
      @(negedge clock);
      forever begin
         mode = $urandom_range(0, 2);
         repeat ($urandom_range(5, 40)) begin
            case (mode)
               0: rsp_ready <= 1'b1;
               1: rsp_ready <= ($urandom_range(0, 3) != 0);
               default: rsp_ready <= ($urandom_range(0, 3) == 0);
            endcase
            @(negedge clock);
         end
      end
   end

   // Guards against a hung block.
   initial begin
      #5ms;
      $display("CHECKS FAILED");
      $finish;
   end

   initial begin
      int len;
      int waited;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed part: empty message, both finish forms, the unused command,
      // extreme byte values, a message whose padding spills into a second
      // block, and one whose last data byte completes a block.
      send_request(md5sh_pkg::CMD_FINISH, 8'hff);
      send_request(CMD_IGNORED, 8'h5a);
      send_request(md5sh_pkg::CMD_DATA_FINISH, 8'h00);
      send_request(md5sh_pkg::CMD_DATA, 8'hff);
      send_request(md5sh_pkg::CMD_DATA, 8'haa);
      send_request(CMD_IGNORED, 8'h55);
      send_request(md5sh_pkg::CMD_DATA_FINISH, 8'h55);
      send_message(55, 1'b1);
      send_message(63, 1'b1);

      // Random part: short complete messages, with some ignored commands
      // mixed in as noise.
      for (int m = 0; m < 8; m++) begin
         len = $urandom_range(0, 12);
         for (int i = 0; i < len; i++) begin
            if ($urandom_range(0, 15) == 0) send_request(CMD_IGNORED, 8'($urandom));
            send_request(md5sh_pkg::CMD_DATA, 8'($urandom));
         end
         send_request($urandom_range(0, 1) ? md5sh_pkg::CMD_DATA_FINISH
                                           : md5sh_pkg::CMD_FINISH, 8'($urandom));
      end
      req_valid <= 1'b0;

      waited = 0;
      while (words_pending != 0 && waited < 20000) begin
         @(posedge clock);
         waited++;
      end
      repeat (200) @(posedge clock);
      if (fail_count == 0 && words_pending == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end
endmodule

### sim.f
sv/md5sh_pkg.sv
sv/md5sh_core.sv
sv/md5_stream_hasher.sv
sv/md5sh_checker.sv
verif/md5_stream_hasher_checker.sv
verif/md5_stream_hasher_tb.sv
